### hdl/scra_pkg.sv
`timescale 1ns / 1ps

package scra_pkg;

  // Sizing of the allocator
  localparam int NUM_CLASSES       = 38;
  localparam int SLOTS_PER_BLOCK   = 16;
  localparam int BLOCK_BYTES       = 4096;
  localparam int BLOCK_STORE_DEPTH = 256;

  // Field widths
  localparam int OFF_W  = 56;
  localparam int SIZE_W = 43;
  localparam int REC_W  = 64;
  localparam int CLS_W  = 6;
  localparam int RCLS_W = REC_W - OFF_W;

  // Derived index widths
  localparam int CLS_AW  = $clog2(NUM_CLASSES);
  localparam int SLOT_W  = $clog2(SLOTS_PER_BLOCK);
  localparam int BLK_AW  = $clog2(BLOCK_STORE_DEPTH);
  localparam int BLK_W   = BLK_AW + 1;
  localparam int SLOT_AW = BLK_AW + SLOT_W;

  localparam logic [BLK_W-1:0] NO_BLOCK        = BLK_W'(BLOCK_STORE_DEPTH);
  localparam logic [OFF_W-1:0] START_RESET     = OFF_W'(4096);
  localparam logic [OFF_W-1:0] MIN_CLASS_BYTES = OFF_W'(32);

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2,
    CMD_NONE   = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [SIZE_W-1:0] req_size;
    logic [REC_W-1:0]  record_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [REC_W-1:0] record_out;
    logic [OFF_W-1:0] place_offset;
    logic [CLS_W-1:0] size_class;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic rd_head;
    logic alloc_sel;
    logic latch_head;
    logic latch_mask;
    logic set_slot_free;
    logic new_blk;
    logic rd_spare;
    logic latch_spare;
    logic link;
    logic put;
    logic rd_slot;
    logic take;
    logic retire;
    logic bump;
    logic res_zero;
    logic res_too_large;
    logic res_keep;
    logic res_exhaust;
    logic res_alloc;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] command;
    logic       fit;
    logic       bad_cls;
    logic       same_cls;
    logic       head_valid;
    logic       has_empty;
    logic       has_full;
    logic       keep_head;
    logic       avail;
    logic       spare_valid;
  } dp_sts_t;

endpackage

### hdl/scra_ram.sv
`timescale 1ns / 1ps

module scra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/scra_dp.sv
`timescale 1ns / 1ps

module scra_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scra_pkg::in_item_t         in_data_i,
  input  logic                       cfg_we_i,
  input  logic [scra_pkg::OFF_W-1:0] cfg_data_i,
  input  scra_pkg::dp_cmd_t          cmd_i,
  output scra_pkg::dp_sts_t          sts_o,
  output scra_pkg::out_item_t        out_data_o
);

  scra_pkg::in_item_t                 req_q;
  scra_pkg::out_item_t                res_q;
  logic [scra_pkg::CLS_AW-1:0]        cls_q;
  logic [scra_pkg::BLK_W-1:0]         head_q;
  logic [scra_pkg::BLK_W-1:0]         blk_q;
  logic [scra_pkg::BLK_W-1:0]         spare_q;
  logic [scra_pkg::BLK_W-1:0]         used_q;
  logic [scra_pkg::SLOTS_PER_BLOCK-1:0] m_q;
  logic [scra_pkg::SLOT_W-1:0]        slot_q;
  logic [scra_pkg::OFF_W-1:0]         ep_q;
  logic [scra_pkg::OFF_W-1:0]         place_q;
  logic [scra_pkg::NUM_CLASSES-1:0]   ch_vld_q;
  logic                               hv_rd_q;

  logic                               fit;
  logic [scra_pkg::CLS_AW-1:0]        acls;
  logic [scra_pkg::CLS_AW-1:0]        fcls;
  logic [scra_pkg::RCLS_W-1:0]        rec_cls;
  logic [scra_pkg::SLOT_W-1:0]        lo_empty;
  logic [scra_pkg::SLOT_W-1:0]        hi_full;
  logic [scra_pkg::SLOTS_PER_BLOCK-1:0] slot_oh;

  logic [scra_pkg::CLS_AW-1:0]        ch_raddr;
  logic                               ch_we;
  logic [scra_pkg::BLK_W-1:0]         ch_wdata;
  logic [scra_pkg::BLK_W-1:0]         ch_rd;
  logic [scra_pkg::BLK_AW-1:0]        blk_raddr;
  logic                               mk_we;
  logic [scra_pkg::SLOTS_PER_BLOCK-1:0] mk_wdata;
  logic [scra_pkg::SLOTS_PER_BLOCK-1:0] mk_rd;
  logic                               nx_we;
  logic [scra_pkg::BLK_W-1:0]         nx_wdata;
  logic [scra_pkg::BLK_W-1:0]         nx_rd;
  logic [scra_pkg::OFF_W-1:0]         sl_rd;

  assign rec_cls = req_q.record_in[scra_pkg::REC_W-1:scra_pkg::OFF_W];
  assign fcls    = req_q.record_in[scra_pkg::OFF_W +: scra_pkg::CLS_AW];

  // Smallest class whose byte size holds the requested size.
  always_comb begin
    fit  = 1'b0;
    acls = '0;
    for (int i = scra_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
      if (((scra_pkg::SIZE_W + 1)'(32) << i) >= {1'b0, req_q.req_size}) begin
        fit  = 1'b1;
        acls = scra_pkg::CLS_AW'(i);
      end
    end
  end

  // Lowest empty slot and highest filled slot of the loaded block mask.
  always_comb begin
    lo_empty = '0;
    hi_full  = '0;
    for (int i = scra_pkg::SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
      if (!m_q[i]) begin
        lo_empty = scra_pkg::SLOT_W'(i);
      end
    end
    for (int i = 0; i < scra_pkg::SLOTS_PER_BLOCK; i++) begin
      if (m_q[i]) begin
        hi_full = scra_pkg::SLOT_W'(i);
      end
    end
  end

  assign slot_oh = scra_pkg::SLOTS_PER_BLOCK'(1) << slot_q;

  // Memory port selection.
  assign ch_raddr  = cmd_i.alloc_sel ? acls : fcls;
  assign ch_we     = cmd_i.link | cmd_i.retire;
  assign ch_wdata  = cmd_i.link ? blk_q : nx_rd;
  assign blk_raddr = cmd_i.rd_spare ? spare_q[scra_pkg::BLK_AW-1:0]
                                    : blk_q[scra_pkg::BLK_AW-1:0];
  assign mk_we     = cmd_i.put | cmd_i.take;
  assign mk_wdata  = cmd_i.put ? (m_q | slot_oh) : (m_q & ~slot_oh);
  assign nx_we     = cmd_i.link | cmd_i.retire;
  assign nx_wdata  = cmd_i.link ? head_q : spare_q;

  scra_ram #(.WIDTH(scra_pkg::BLK_W), .DEPTH(scra_pkg::NUM_CLASSES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (cls_q),
    .wdata_i (ch_wdata),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rd)
  );

  scra_ram #(.WIDTH(scra_pkg::SLOTS_PER_BLOCK),
             .DEPTH(scra_pkg::BLOCK_STORE_DEPTH)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (blk_q[scra_pkg::BLK_AW-1:0]),
    .wdata_i (mk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (mk_rd)
  );

  scra_ram #(.WIDTH(scra_pkg::BLK_W), .DEPTH(scra_pkg::BLOCK_STORE_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (blk_q[scra_pkg::BLK_AW-1:0]),
    .wdata_i (nx_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (nx_rd)
  );

  scra_ram #(.WIDTH(scra_pkg::OFF_W),
             .DEPTH(scra_pkg::BLOCK_STORE_DEPTH * scra_pkg::SLOTS_PER_BLOCK)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.put),
    .waddr_i ({blk_q[scra_pkg::BLK_AW-1:0], slot_q}),
    .wdata_i (req_q.record_in[scra_pkg::OFF_W-1:0]),
    .raddr_i ({blk_q[scra_pkg::BLK_AW-1:0], hi_full}),
    .rdata_o (sl_rd)
  );

  // Allocator control state: end pointer, spare list, block count, head valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_q     <= scra_pkg::START_RESET;
      spare_q  <= scra_pkg::NO_BLOCK;
      used_q   <= '0;
      ch_vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ep_q <= cfg_data_i;
      end else if (cmd_i.new_blk) begin
        ep_q <= ep_q + scra_pkg::OFF_W'(scra_pkg::BLOCK_BYTES);
      end else if (cmd_i.bump) begin
        ep_q <= ep_q + (scra_pkg::MIN_CLASS_BYTES << cls_q);
      end
      if (cmd_i.new_blk) begin
        used_q <= used_q + scra_pkg::BLK_W'(1);
      end
      if (cmd_i.latch_spare) begin
        spare_q <= nx_rd;
      end else if (cmd_i.retire) begin
        spare_q <= blk_q;
      end
      if (ch_we) begin
        ch_vld_q[cls_q] <= 1'b1;
      end
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (cmd_i.rd_head) begin
      cls_q   <= ch_raddr;
      hv_rd_q <= ch_vld_q[ch_raddr];
    end
    if (cmd_i.latch_head) begin
      head_q <= hv_rd_q ? ch_rd : scra_pkg::NO_BLOCK;
      blk_q  <= hv_rd_q ? ch_rd : scra_pkg::NO_BLOCK;
    end else if (cmd_i.new_blk) begin
      blk_q <= used_q;
    end else if (cmd_i.rd_spare) begin
      blk_q <= spare_q;
    end
    if (cmd_i.latch_mask || cmd_i.latch_spare) begin
      m_q <= mk_rd;
    end else if (cmd_i.new_blk) begin
      m_q <= '0;
    end else if (cmd_i.take) begin
      m_q <= mk_wdata;
    end
    if (cmd_i.set_slot_free) begin
      slot_q <= lo_empty;
    end else if (cmd_i.rd_slot) begin
      slot_q <= hi_full;
    end else if (cmd_i.new_blk || cmd_i.latch_spare) begin
      slot_q <= '0;
    end
    if (cmd_i.take) begin
      place_q <= sl_rd;
    end else if (cmd_i.bump) begin
      place_q <= ep_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero || cmd_i.res_too_large) begin
      res_q.status       <= cmd_i.res_too_large ? scra_pkg::ST_TOO_LARGE : scra_pkg::ST_OK;
      res_q.record_out   <= '0;
      res_q.place_offset <= '0;
      res_q.size_class   <= '0;
    end else if (cmd_i.res_keep) begin
      res_q.status       <= scra_pkg::ST_OK;
      res_q.record_out   <= req_q.record_in;
      res_q.place_offset <= req_q.record_in[scra_pkg::OFF_W-1:0];
      res_q.size_class   <= req_q.record_in[scra_pkg::OFF_W +: scra_pkg::CLS_W];
    end else if (cmd_i.res_exhaust) begin
      res_q.status       <= scra_pkg::ST_EXHAUSTED;
      res_q.record_out   <= '0;
      res_q.place_offset <= '0;
      res_q.size_class   <= req_q.record_in[scra_pkg::OFF_W +: scra_pkg::CLS_W];
    end else if (cmd_i.res_alloc) begin
      res_q.status       <= scra_pkg::ST_OK;
      res_q.record_out   <= {scra_pkg::RCLS_W'(cls_q), place_q};
      res_q.place_offset <= place_q;
      res_q.size_class   <= scra_pkg::CLS_W'(cls_q);
    end
  end

  assign out_data_o = res_q;

  // Status back to the controller.
  always_comb begin
    sts_o.command     = req_q.command;
    sts_o.fit         = fit;
    sts_o.bad_cls     = rec_cls >= scra_pkg::RCLS_W'(scra_pkg::NUM_CLASSES);
    sts_o.same_cls    = scra_pkg::RCLS_W'(acls) == rec_cls;
    sts_o.head_valid  = head_q != scra_pkg::NO_BLOCK;
    sts_o.has_empty   = ~&m_q;
    sts_o.has_full    = |m_q;
    sts_o.keep_head   = m_q[0] && (slot_q != '0);
    sts_o.avail       = (spare_q != scra_pkg::NO_BLOCK) ||
                        (used_q < scra_pkg::BLK_W'(scra_pkg::BLOCK_STORE_DEPTH));
    sts_o.spare_valid = spare_q != scra_pkg::NO_BLOCK;
  end

  // The block count never passes the store depth.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= scra_pkg::BLK_W'(scra_pkg::BLOCK_STORE_DEPTH))
    else $error("block count beyond store depth");

  // A fresh block is only taken while the store has room.
  a_new_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.new_blk |-> used_q < scra_pkg::BLK_W'(scra_pkg::BLOCK_STORE_DEPTH))
    else $error("new block taken from a full store");

  // A free fills an empty slot and an allocation empties a filled one.
  a_put_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put |-> !m_q[slot_q])
    else $error("free into a filled slot");

  a_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take |-> m_q[slot_q])
    else $error("allocation from an empty slot");

endmodule

### hdl/scra_ctrl.sv
`timescale 1ns / 1ps

module scra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  scra_pkg::dp_sts_t sts_i,
  output scra_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [23:0] {
    S_IDLE   = 24'd1 << 0,
    S_CHECK  = 24'd1 << 1,
    S_F_RH   = 24'd1 << 2,
    S_F_LH   = 24'd1 << 3,
    S_F_RM   = 24'd1 << 4,
    S_F_LM   = 24'd1 << 5,
    S_F_SCAN = 24'd1 << 6,
    S_F_NEW  = 24'd1 << 7,
    S_F_SPR  = 24'd1 << 8,
    S_F_SPL  = 24'd1 << 9,
    S_F_NB   = 24'd1 << 10,
    S_F_LINK = 24'd1 << 11,
    S_F_PUT  = 24'd1 << 12,
    S_A_RH   = 24'd1 << 13,
    S_A_LH   = 24'd1 << 14,
    S_A_RM   = 24'd1 << 15,
    S_A_LM   = 24'd1 << 16,
    S_A_SCAN = 24'd1 << 17,
    S_A_RD   = 24'd1 << 18,
    S_A_RET  = 24'd1 << 19,
    S_A_RETL = 24'd1 << 20,
    S_A_BUMP = 24'd1 << 21,
    S_A_RES  = 24'd1 << 22,
    S_OUT    = 24'd1 << 23
  } state_e;

  state_e state_q, state_d;
  logic   bump_q, bump_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bump_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bump_q  <= bump_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  // Sequencer: a free phase, an allocation phase, or both for a resize, then the result transaction.
  always_comb begin
    state_d = state_q;
    bump_d  = bump_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (scra_pkg::command_e'(sts_i.command))
          scra_pkg::CMD_ALLOC: begin
            if (sts_i.fit) begin
              state_d = S_A_RH;
            end else begin
              cmd_o.res_too_large = 1'b1;
              state_d = S_OUT;
            end
          end
          scra_pkg::CMD_FREE: begin
            if (sts_i.bad_cls) begin
              cmd_o.res_too_large = 1'b1;
              state_d = S_OUT;
            end else begin
              state_d = S_F_RH;
            end
          end
          scra_pkg::CMD_RESIZE: begin
            if (sts_i.bad_cls || !sts_i.fit) begin
              cmd_o.res_too_large = 1'b1;
              state_d = S_OUT;
            end else if (sts_i.same_cls) begin
              cmd_o.res_keep = 1'b1;
              state_d = S_OUT;
            end else begin
              state_d = S_F_RH;
            end
          end
          default: begin
            cmd_o.res_zero = 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_F_RH: begin
        cmd_o.rd_head = 1'b1;
        state_d = S_F_LH;
      end
      S_F_LH: begin
        cmd_o.latch_head = 1'b1;
        state_d = S_F_RM;
      end
      S_F_RM: begin
        if (sts_i.head_valid) begin
          state_d = S_F_LM;
        end else begin
          state_d = S_F_NEW;
        end
      end
      S_F_LM: begin
        cmd_o.latch_mask = 1'b1;
        state_d = S_F_SCAN;
      end
      S_F_SCAN: begin
        if (sts_i.has_empty) begin
          cmd_o.set_slot_free = 1'b1;
          state_d = S_F_PUT;
        end else begin
          state_d = S_F_NEW;
        end
      end
      S_F_NEW: begin
        if (!sts_i.avail) begin
          cmd_o.res_exhaust = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.spare_valid) begin
          state_d = S_F_SPR;
        end else begin
          state_d = S_F_NB;
        end
      end
      S_F_SPR: begin
        cmd_o.rd_spare = 1'b1;
        state_d = S_F_SPL;
      end
      S_F_SPL: begin
        cmd_o.latch_spare = 1'b1;
        state_d = S_F_LINK;
      end
      S_F_NB: begin
        cmd_o.new_blk = 1'b1;
        state_d = S_F_LINK;
      end
      S_F_LINK: begin
        cmd_o.link = 1'b1;
        state_d = S_F_PUT;
      end
      S_F_PUT: begin
        cmd_o.put = 1'b1;
        if (scra_pkg::command_e'(sts_i.command) == scra_pkg::CMD_RESIZE) begin
          state_d = S_A_RH;
        end else begin
          cmd_o.res_keep = 1'b1;
          state_d = S_OUT;
        end
      end
      S_A_RH: begin
        cmd_o.rd_head   = 1'b1;
        cmd_o.alloc_sel = 1'b1;
        state_d = S_A_LH;
      end
      S_A_LH: begin
        cmd_o.latch_head = 1'b1;
        state_d = S_A_RM;
      end
      S_A_RM: begin
        if (sts_i.head_valid) begin
          state_d = S_A_LM;
        end else begin
          state_d = S_A_BUMP;
        end
      end
      S_A_LM: begin
        cmd_o.latch_mask = 1'b1;
        state_d = S_A_SCAN;
      end
      S_A_SCAN: begin
        if (sts_i.has_full) begin
          cmd_o.rd_slot = 1'b1;
          state_d = S_A_RD;
        end else begin
          // Head block holds nothing: retire it and take fresh space.
          bump_d  = 1'b1;
          state_d = S_A_RET;
        end
      end
      S_A_RD: begin
        cmd_o.take = 1'b1;
        if (sts_i.keep_head) begin
          state_d = S_A_RES;
        end else begin
          bump_d  = 1'b0;
          state_d = S_A_RET;
        end
      end
      S_A_RET: begin
        // The link table read of the head block completes here.
        state_d = S_A_RETL;
      end
      S_A_RETL: begin
        cmd_o.retire = 1'b1;
        state_d = bump_q ? S_A_BUMP : S_A_RES;
      end
      S_A_BUMP: begin
        cmd_o.bump = 1'b1;
        state_d = S_A_RES;
      end
      S_A_RES: begin
        cmd_o.res_alloc = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/size_class_record_allocator_top.sv
`timescale 1ns / 1ps

// Size-class record allocator. Each input transaction (allocate, free or resize)
// gives exactly one result transaction; the block takes one transaction at a time
// and stalls its input until the result has been taken. The time from one input
// acceptance to the next depends on the request (a rejected, unchanged or unused
// request is shortest; a resize whose free chains a spare block and whose
// allocation retires an emptied block is among the longest) and on result stalls;
// it is set by the controller walking the class head table, the block mask, the
// link table and the slot store, each a memory with one write port and a registered
// read port. start_offset is written through cfg_we_i / cfg_data_i and reloads the
// end pointer at once; the user must write it only while idle (not enforced).
module size_class_record_allocator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  scra_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output scra_pkg::out_item_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [scra_pkg::OFF_W-1:0] cfg_data_i
);

  scra_pkg::dp_cmd_t cmd;
  scra_pkg::dp_sts_t sts;

  scra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  scra_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

### tb/scra_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port, keeps its own copy of the
// allocator state, and compares every result transaction with the oldest
// expected one.
module scra_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  scra_pkg::in_item_t         in_data_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  scra_pkg::out_item_t        out_data_i,
  input  logic                       cfg_we_i,
  input  logic [scra_pkg::OFF_W-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_o,
  output int                         exhausted_o
);

  localparam int NSLOT = scra_pkg::BLOCK_STORE_DEPTH * scra_pkg::SLOTS_PER_BLOCK;

  // Mirror of the allocator state.
  logic [scra_pkg::OFF_W-1:0]           end_ptr;
  logic [scra_pkg::BLK_W-1:0]           class_head [scra_pkg::NUM_CLASSES];
  logic [scra_pkg::BLK_W-1:0]           spare_head;
  logic [scra_pkg::BLK_W-1:0]           blk_next   [scra_pkg::BLOCK_STORE_DEPTH];
  logic [scra_pkg::OFF_W-1:0]           slot_off   [NSLOT];
  logic [scra_pkg::SLOTS_PER_BLOCK-1:0] slot_full  [scra_pkg::BLOCK_STORE_DEPTH];
  int unsigned                          blocks_used;

  scra_pkg::out_item_t expected_q[$];

  function automatic void clear_state();
    end_ptr     = scra_pkg::START_RESET;
    spare_head  = scra_pkg::NO_BLOCK;
    blocks_used = 0;
    for (int i = 0; i < scra_pkg::NUM_CLASSES; i++) class_head[i] = scra_pkg::NO_BLOCK;
  endfunction

  // Smallest class whose size holds sz; returns 0 when none does.
  function automatic bit fit_class(input logic [scra_pkg::SIZE_W-1:0] sz, output int cls);
    cls = 0;
    for (int i = 0; i < scra_pkg::NUM_CLASSES && i <= 58; i++) begin
      if ((64'd32 << i) >= 64'(sz)) begin
        cls = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Puts a spare or fresh block in front of the class chain.
  function automatic int chain_front(input int cls);
    int b;
    if (spare_head != scra_pkg::NO_BLOCK) begin
      b = spare_head;
      spare_head = blk_next[b];
    end else begin
      b = blocks_used;
      blocks_used++;
      end_ptr = end_ptr + scra_pkg::OFF_W'(scra_pkg::BLOCK_BYTES);
      slot_full[b] = '0;
    end
    blk_next[b] = class_head[cls];
    class_head[cls] = scra_pkg::BLK_W'(b);
    return b;
  endfunction

  function automatic void retire_front(input int cls);
    int h;
    h = class_head[cls];
    class_head[cls] = blk_next[h];
    blk_next[h] = spare_head;
    spare_head = scra_pkg::BLK_W'(h);
  endfunction

  // Returns the status of releasing an offset into its class.
  function automatic scra_pkg::status_e release_off(input int cls,
                                                    input logic [scra_pkg::OFF_W-1:0] off);
    int h;
    int s;
    h = class_head[cls];
    s = scra_pkg::SLOTS_PER_BLOCK;
    if (h != scra_pkg::NO_BLOCK) begin
      for (int i = 0; i < scra_pkg::SLOTS_PER_BLOCK; i++) begin
        if (!slot_full[h][i]) begin
          s = i;
          break;
        end
      end
    end
    if (s >= scra_pkg::SLOTS_PER_BLOCK) begin
      if (spare_head == scra_pkg::NO_BLOCK && blocks_used >= scra_pkg::BLOCK_STORE_DEPTH)
        return scra_pkg::ST_EXHAUSTED;
      h = chain_front(cls);
      s = 0;
    end
    slot_off[h*scra_pkg::SLOTS_PER_BLOCK+s] = off;
    slot_full[h][s] = 1'b1;
    return scra_pkg::ST_OK;
  endfunction

  function automatic logic [scra_pkg::OFF_W-1:0] take_off(input int cls);
    int h;
    logic [scra_pkg::OFF_W-1:0] off;
    h = class_head[cls];
    if (h != scra_pkg::NO_BLOCK) begin
      for (int i = scra_pkg::SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
        if (slot_full[h][i]) begin
          slot_full[h][i] = 1'b0;
          off = slot_off[h*scra_pkg::SLOTS_PER_BLOCK+i];
          if (!slot_full[h][0]) retire_front(cls);
          return off;
        end
      end
      retire_front(cls);
    end
    off = end_ptr;
    end_ptr = end_ptr + (scra_pkg::OFF_W'(32) << cls);
    return off;
  endfunction

  function automatic scra_pkg::out_item_t predict_result(input scra_pkg::in_item_t it);
    scra_pkg::out_item_t r;
    int c;
    int rc;
    logic [scra_pkg::OFF_W-1:0] roff;
    bit fits;
    r = '0;
    rc = it.record_in[scra_pkg::REC_W-1:scra_pkg::OFF_W];
    roff = it.record_in[scra_pkg::OFF_W-1:0];
    fits = fit_class(it.req_size, c);
    case (scra_pkg::command_e'(it.command))
      scra_pkg::CMD_ALLOC: begin
        if (!fits) r.status = scra_pkg::ST_TOO_LARGE;
        else begin
          r.place_offset = take_off(c);
          r.record_out = {scra_pkg::RCLS_W'(c), r.place_offset};
          r.size_class = scra_pkg::CLS_W'(c);
        end
      end
      scra_pkg::CMD_FREE: begin
        if (rc >= scra_pkg::NUM_CLASSES) r.status = scra_pkg::ST_TOO_LARGE;
        else begin
          r.size_class = scra_pkg::CLS_W'(rc);
          r.status = release_off(rc, roff);
          if (r.status == scra_pkg::ST_OK) begin
            r.record_out = it.record_in;
            r.place_offset = roff;
          end
        end
      end
      scra_pkg::CMD_RESIZE: begin
        if (rc >= scra_pkg::NUM_CLASSES || !fits) r.status = scra_pkg::ST_TOO_LARGE;
        else if (c == rc) begin
          r.record_out = it.record_in;
          r.place_offset = roff;
          r.size_class = scra_pkg::CLS_W'(c);
        end else begin
          r.status = release_off(rc, roff);
          if (r.status == scra_pkg::ST_OK) begin
            r.place_offset = take_off(c);
            r.record_out = {scra_pkg::RCLS_W'(c), r.place_offset};
            r.size_class = scra_pkg::CLS_W'(c);
          end else begin
            r.size_class = scra_pkg::CLS_W'(rc);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compare, apply configuration, then predict, all on the sampled edge values.
  always @(posedge clk_i or negedge rst_ni) begin
    scra_pkg::out_item_t want;
    if (!rst_ni) begin
      clear_state();
      expected_q.delete();
      fail_count_o = 0;
      results_o = 0;
      exhausted_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_data_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (want.status == scra_pkg::ST_EXHAUSTED) exhausted_o++;
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
            fail_count_o++;
          end
          if (out_data_i.record_out !== want.record_out) begin
            $error("record_out: expected %h, got %h", want.record_out,
                   out_data_i.record_out);
            fail_count_o++;
          end
          if (out_data_i.place_offset !== want.place_offset) begin
            $error("place_offset: expected %h, got %h", want.place_offset,
                   out_data_i.place_offset);
            fail_count_o++;
          end
          if (out_data_i.size_class !== want.size_class) begin
            $error("size_class: expected %0d, got %0d", want.size_class,
                   out_data_i.size_class);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        end_ptr = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_result(in_data_i));
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/tb_size_class_record_allocator_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the size-class record allocator.
module tb_size_class_record_allocator_top;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  scra_pkg::in_item_t           in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  scra_pkg::out_item_t          out_data_o;
  logic                         cfg_we_i = 1'b0;
  logic [scra_pkg::OFF_W-1:0]   cfg_data_i = '0;

  int fail_count;
  int pending;
  int results;
  int exhausted;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int cfg_writes;

  always #5 clk_i = ~clk_i;

  size_class_record_allocator_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_data_i
  );

  scra_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .results_o(results), .exhausted_o(exhausted)
  );

  // Receiver: random stalls, or a long hold-off counted here when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_cycles <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #20ms;
    $display("FAIL size_class_record_allocator_top");
    $finish;
  end

  function automatic logic [scra_pkg::OFF_W-1:0] rand_off();
    return {$urandom, $urandom};
  endfunction

  function automatic scra_pkg::in_item_t make_item(input scra_pkg::command_e cmd,
                                                   input logic [scra_pkg::SIZE_W-1:0] sz,
                                                   input logic [scra_pkg::REC_W-1:0] rec);
    scra_pkg::in_item_t it;
    it.command = cmd;
    it.req_size = sz;
    it.record_in = rec;
    return it;
  endfunction

  // Offers one transaction after a random gap and returns once it is taken.
  task automatic offer(input scra_pkg::in_item_t it);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Register write once every result is in and the block has settled.
  task automatic write_start(input logic [scra_pkg::OFF_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  // Mostly plausible records of small classes; some wholly random ones.
  task automatic random_item();
    int pick;
    logic [scra_pkg::SIZE_W-1:0] sz;
    logic [scra_pkg::REC_W-1:0] rec;
    pick = $urandom_range(99);
    sz = (pick % 10 == 0) ? scra_pkg::SIZE_W'({$urandom, $urandom})
                          : scra_pkg::SIZE_W'($urandom_range(0, 4096));
    rec = {8'($urandom_range(0, 7)), rand_off() & ~scra_pkg::OFF_W'(31)};
    if (pick < 42) offer(make_item(scra_pkg::CMD_ALLOC, sz, rec));
    else if (pick < 74) offer(make_item(scra_pkg::CMD_FREE, sz, rec));
    else if (pick < 92) offer(make_item(scra_pkg::CMD_RESIZE, sz, rec));
    else if (pick < 95)
      offer(make_item(scra_pkg::command_e'($urandom_range(0, 3)),
                      scra_pkg::SIZE_W'({$urandom, $urandom}), {$urandom, $urandom}));
    else offer(make_item(scra_pkg::CMD_FREE, sz, {8'($urandom_range(38, 255)), rand_off()}));
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_writes = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size and record extremes, every command, rejections.
    offer(make_item(scra_pkg::CMD_ALLOC, '0, '0));
    offer(make_item(scra_pkg::CMD_ALLOC, scra_pkg::SIZE_W'(1), '0));
    offer(make_item(scra_pkg::CMD_ALLOC, scra_pkg::SIZE_W'(32), '0));
    offer(make_item(scra_pkg::CMD_ALLOC, scra_pkg::SIZE_W'(33), '0));
    offer(make_item(scra_pkg::CMD_ALLOC, scra_pkg::SIZE_W'(64'd1 << 42), '0));
    offer(make_item(scra_pkg::CMD_ALLOC, scra_pkg::SIZE_W'((64'd1 << 42) + 1), '0));
    offer(make_item(scra_pkg::CMD_ALLOC, '1, '1));
    offer(make_item(scra_pkg::CMD_FREE, '0, {8'd37, {scra_pkg::OFF_W{1'b1}}}));
    offer(make_item(scra_pkg::CMD_FREE, '0, {8'd38, rand_off()}));
    offer(make_item(scra_pkg::CMD_FREE, '1, '1));
    offer(make_item(scra_pkg::CMD_RESIZE, scra_pkg::SIZE_W'(40), {8'd1, scra_pkg::OFF_W'(256)}));
    offer(make_item(scra_pkg::CMD_RESIZE, scra_pkg::SIZE_W'(500), {8'd1, scra_pkg::OFF_W'(512)}));
    offer(make_item(scra_pkg::CMD_RESIZE, '1, {8'd1, scra_pkg::OFF_W'(512)}));
    offer(make_item(scra_pkg::CMD_RESIZE, scra_pkg::SIZE_W'(32), {8'd200, scra_pkg::OFF_W'(64)}));
    offer(make_item(scra_pkg::CMD_NONE, '1, '1));
    // A full block chains a second one; draining both sends them to the spare list.
    for (int i = 0; i < 17; i++)
      offer(make_item(scra_pkg::CMD_FREE, '0, {8'd3, scra_pkg::OFF_W'(i * 256)}));
    for (int i = 0; i < 18; i++)
      offer(make_item(scra_pkg::CMD_ALLOC, scra_pkg::SIZE_W'(200), '0));
    offer(make_item(scra_pkg::CMD_FREE, '0, {8'd9, scra_pkg::OFF_W'(1024)}));

    // Random phases under different idle patterns and register settings.
    write_start('0);
    send_idle_pct = 32;
    recv_idle_pct = 73;
    for (int i = 0; i < 300; i++) begin
      if (i == 150) hold_req = ~hold_req;
      random_item();
    end
    write_start('1);
    send_idle_pct = 73;
    recv_idle_pct = 32;
    for (int i = 0; i < 300; i++) random_item();
    write_start(rand_off());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 300; i++) random_item();
    in_valid_i <= 1'b0;

    // Drain and verdict.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Checked %0d results (%0d with an exhausted block store) over three idle patterns,",
             results, exhausted);
    $display("a long output hold-off and %0d start offset settings.", cfg_writes);
    if (fail_count == 0) begin
      $display("PASS size_class_record_allocator_top");
    end else begin
      $display("FAIL size_class_record_allocator_top");
    end
    $finish;
  end

endmodule

### sim.f
hdl/scra_pkg.sv
hdl/scra_ram.sv
hdl/scra_dp.sv
hdl/scra_ctrl.sv
hdl/size_class_record_allocator_top.sv
tb/scra_checker.sv
tb/tb_size_class_record_allocator_top.sv
